// ===== sv/x86_prefix_parser_unit_assert.svh =====
// Assertion macros for the x86 prefix parser unit.
// Depends on a clock named clk and an active-low reset named rst_n in the using scope.
`ifndef X86_PREFIX_PARSER_UNIT_ASSERT_SVH
`define X86_PREFIX_PARSER_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define XPP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define XPP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/xpp_pkg.sv =====
// Shared types, prefix encodings and byte classifiers for the x86 prefix parser.
// No dependencies; used by every module of the block.
package xpp_pkg;

    // Segment override codes as reported in the result.
    typedef enum logic [2:0] {
        SEG_NONE,
        SEG_ES,
        SEG_CS,
        SEG_SS,
        SEG_DS,
        SEG_FS,
        SEG_GS
    } seg_t;

    // Group-one prefix codes (wait, lock, rep) as reported in the result.
    typedef enum logic [2:0] {
        GRP_NONE,
        GRP_WAIT,
        GRP_LOCK,
        GRP_REPNZ,
        GRP_REPZ
    } grp_t;

    // Prefix byte encodings.
    localparam logic [7:0] BYTE_ES       = 8'h26;
    localparam logic [7:0] BYTE_CS       = 8'h2E;
    localparam logic [7:0] BYTE_SS       = 8'h36;
    localparam logic [7:0] BYTE_DS       = 8'h3E;
    localparam logic [7:0] BYTE_FS       = 8'h64;
    localparam logic [7:0] BYTE_GS       = 8'h65;
    localparam logic [7:0] BYTE_OPSIZE   = 8'h66;
    localparam logic [7:0] BYTE_ADDRSIZE = 8'h67;
    localparam logic [7:0] BYTE_WAIT     = 8'h9B;
    localparam logic [7:0] BYTE_LOCK     = 8'hF0;
    localparam logic [7:0] BYTE_REPNZ    = 8'hF2;
    localparam logic [7:0] BYTE_REPZ     = 8'hF3;
    localparam logic [7:0] BYTE_ESCAPE   = 8'h0F;

    localparam logic [3:0] COUNT_MAX = 4'd15;

    // Prefixes collected so far in the current run.
    typedef struct packed {
        seg_t       seg;
        logic       opsize;
        logic       addrsize;
        grp_t       grp;
        logic [3:0] count;
    } run_state_t;

    localparam run_state_t RUN_CLEAR = '{
        seg:      SEG_NONE,
        opsize:   1'b0,
        addrsize: 1'b0,
        grp:      GRP_NONE,
        count:    4'd0
    };

    // One result, emitted by the byte that ends a run.
    typedef struct packed {
        seg_t       seg;
        logic       opsize;
        logic       addrsize;
        grp_t       grp;
        logic       escape;
        logic [7:0] ending_byte;
        logic [3:0] count;
    } result_t;

    // Segment code of a byte, SEG_NONE if it is not a segment override.
    function automatic seg_t seg_code(input logic [7:0] b);
        seg_t s;
        case (b)
            BYTE_ES: s = SEG_ES;
            BYTE_CS: s = SEG_CS;
            BYTE_SS: s = SEG_SS;
            BYTE_DS: s = SEG_DS;
            BYTE_FS: s = SEG_FS;
            BYTE_GS: s = SEG_GS;
            default: s = SEG_NONE;
        endcase
        return s;
    endfunction

    // Group-one code of a byte, GRP_NONE if it is not wait, lock or rep.
    function automatic grp_t grp_code(input logic [7:0] b);
        grp_t g;
        case (b)
            BYTE_WAIT:  g = GRP_WAIT;
            BYTE_LOCK:  g = GRP_LOCK;
            BYTE_REPNZ: g = GRP_REPNZ;
            BYTE_REPZ:  g = GRP_REPZ;
            default:    g = GRP_NONE;
        endcase
        return g;
    endfunction

    // One-byte string opcodes: ins, outs, movs, cmps, stos, lods, scas.
    function automatic logic is_string_opcode(input logic [7:0] b);
        return b inside {[8'h6C:8'h6F], [8'hA4:8'hA7], [8'hAA:8'hAF]};
    endfunction

endpackage

// ===== sv/xpp_decode.sv =====
// Per-byte decode: classifies one byte, folds prefixes into the run state
// and forms the fixed-up result for an ending byte. Depends on xpp_pkg.
module xpp_decode (
    input  logic [7:0]          code_byte,
    input  logic                lock_allowed,
    input  logic                cpu_386_or_later,
    input  xpp_pkg::run_state_t state_cur,
    output logic                is_prefix,
    output xpp_pkg::run_state_t state_next,
    output xpp_pkg::result_t    result
);

    xpp_pkg::seg_t seg_in;
    xpp_pkg::grp_t grp_in;
    xpp_pkg::seg_t seg_fix;
    xpp_pkg::grp_t grp_fix;
    logic          escape;

    // Classify the byte.
    always_comb
    begin
        seg_in    = xpp_pkg::seg_code(code_byte);
        grp_in    = xpp_pkg::grp_code(code_byte);
        escape    = (code_byte == xpp_pkg::BYTE_ESCAPE);
        is_prefix = (seg_in != xpp_pkg::SEG_NONE) || (grp_in != xpp_pkg::GRP_NONE) ||
                    (code_byte == xpp_pkg::BYTE_OPSIZE) ||
                    (code_byte == xpp_pkg::BYTE_ADDRSIZE);
    end

    // Absorb a prefix; the first prefix of each group wins.
    always_comb
    begin
        state_next = state_cur;
        if (seg_in != xpp_pkg::SEG_NONE && state_cur.seg == xpp_pkg::SEG_NONE)
        begin
            state_next.seg = seg_in;
        end
        if (grp_in != xpp_pkg::GRP_NONE && state_cur.grp == xpp_pkg::GRP_NONE)
        begin
            state_next.grp = grp_in;
        end
        if (code_byte == xpp_pkg::BYTE_OPSIZE)
        begin
            state_next.opsize = 1'b1;
        end
        if (code_byte == xpp_pkg::BYTE_ADDRSIZE)
        begin
            state_next.addrsize = 1'b1;
        end
        if (state_cur.count != xpp_pkg::COUNT_MAX)
        begin
            state_next.count = state_cur.count + 4'd1;
        end
    end

    // Fix-ups applied when the run ends.
    always_comb
    begin
        grp_fix = state_cur.grp;
        if ((grp_fix == xpp_pkg::GRP_REPNZ || grp_fix == xpp_pkg::GRP_REPZ) &&
            (escape || !xpp_pkg::is_string_opcode(code_byte)))
        begin
            grp_fix = xpp_pkg::GRP_NONE;
        end
        if (grp_fix == xpp_pkg::GRP_LOCK && !lock_allowed)
        begin
            grp_fix = xpp_pkg::GRP_NONE;
        end
        seg_fix = state_cur.seg;
        if (!cpu_386_or_later &&
            (seg_fix == xpp_pkg::SEG_FS || seg_fix == xpp_pkg::SEG_GS))
        begin
            seg_fix = xpp_pkg::SEG_NONE;
        end
        result.seg         = seg_fix;
        result.opsize      = state_cur.opsize;
        result.addrsize    = state_cur.addrsize;
        result.grp         = grp_fix;
        result.escape      = escape;
        result.ending_byte = code_byte;
        result.count       = state_cur.count;
    end

endmodule

// ===== sv/xpp_out_stage.sv =====
// Result register with valid flag for the master-side stream.
// Depends on xpp_pkg for the result type.
module xpp_out_stage (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  xpp_pkg::result_t result_in,
    input  logic             ready,
    output logic             valid,
    output xpp_pkg::result_t result_out,
    output logic             free
);

    logic             valid_reg;
    logic             valid_next;
    xpp_pkg::result_t result_reg;

    // The register can take a new result when empty or being drained.
    assign free       = !valid_reg || ready;
    assign valid_next = load || (valid_reg && !ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload register, no reset needed.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result_in;
        end
    end

    assign valid      = valid_reg;
    assign result_out = result_reg;

endmodule

// ===== sv/x86_prefix_parser_unit.sv =====
// Top level of the x86 prefix parser: input register, run state, decode and result register.
// Depends on xpp_pkg, xpp_decode, xpp_out_stage and x86_prefix_parser_unit_assert.svh.
`include "x86_prefix_parser_unit_assert.svh"

// The unit takes one instruction byte per clock on the slave stream and holds it in an
// input register. Prefix bytes are folded into the run state in the next cycle and produce
// no result. An escape byte or any other non-prefix byte ends the run and loads one result
// into the output register once that register is free, and the result is then offered on the
// master stream. Sustained throughput is one byte per
// clock. It drops only while a finished result waits in the output register and the next
// ending byte reaches the input register; that byte then stalls until the master side takes
// the result. The configuration channel is always ready and should be written only while
// the unit is idle.
module x86_prefix_parser_unit (
    input  logic        clk,
    input  logic        rst_n,
    // Configuration write: bit 0 is cpu_386_or_later.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data,
    // Slave stream of instruction bytes.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] code_byte
    input  logic        s_tuser,   // [0] lock_allowed
    // Master stream of results.
    output logic        m_tvalid,
    input  logic        m_tready,
    // [2:0] segment_override, [3] operand_size_override, [4] address_size_override,
    // [7:5] lock_rep_wait, [15:8] ending_byte, [19:16] prefix_count, [23:20] zero
    output logic [23:0] m_tdata,
    output logic        m_tuser    // [0] two_byte_escape
);

    logic                cpu_386_reg;
    logic                in_valid_reg;
    logic                in_valid_next;
    logic [7:0]          in_byte_reg;
    logic                in_lock_reg;
    logic                accept;
    logic                advance;
    logic                is_prefix;
    logic                out_free;
    logic                out_load;
    xpp_pkg::run_state_t state_reg;
    xpp_pkg::run_state_t state_next;
    xpp_pkg::result_t    result;
    xpp_pkg::result_t    result_out;

    // Configuration register.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cpu_386_reg <= 1'b1;
        end
        else if (cfg_valid)
        begin
            cpu_386_reg <= cfg_data;
        end
    end

    // A byte moves on unless it ends a run while the result register is busy.
    assign advance       = in_valid_reg && (is_prefix || out_free);
    assign out_load      = in_valid_reg && !is_prefix && out_free;
    assign s_tready      = !in_valid_reg || advance;
    assign accept        = s_tvalid && s_tready;
    assign in_valid_next = accept || (in_valid_reg && !advance);

    // Input register control and run state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            state_reg    <= xpp_pkg::RUN_CLEAR;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            if (advance)
            begin
                state_reg <= is_prefix ? state_next : xpp_pkg::RUN_CLEAR;
            end
        end
    end

    // Input payload register.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_byte_reg <= s_tdata;
            in_lock_reg <= s_tuser;
        end
    end

    xpp_decode u_decode (
        .code_byte        (in_byte_reg),
        .lock_allowed     (in_lock_reg),
        .cpu_386_or_later (cpu_386_reg),
        .state_cur        (state_reg),
        .is_prefix        (is_prefix),
        .state_next       (state_next),
        .result           (result)
    );

    xpp_out_stage u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (out_load),
        .result_in  (result),
        .ready      (m_tready),
        .valid      (m_tvalid),
        .result_out (result_out),
        .free       (out_free)
    );

    // Pack the result onto the master stream.
    assign m_tdata = {4'd0, result_out.count, result_out.ending_byte, result_out.grp,
                      result_out.addrsize, result_out.opsize, result_out.seg};
    assign m_tuser = result_out.escape;

    // An ending byte clears the run.
    `XPP_ASSERT_NEXT(a_run_cleared, advance && !is_prefix,
        state_reg == xpp_pkg::RUN_CLEAR, "run state not cleared after ending byte")
    // The prefix count holds at its maximum.
    `XPP_ASSERT_NEXT(a_count_sat, advance && is_prefix && state_reg.count == xpp_pkg::COUNT_MAX,
        state_reg.count == xpp_pkg::COUNT_MAX, "prefix count wrapped")
    // A stalled result is never overwritten.
    `XPP_ASSERT_NOW(a_no_overwrite, m_tvalid && !m_tready,
        !out_load, "result register overwritten while stalled")
    // A rep prefix survives only on a one-byte string opcode.
    `XPP_ASSERT_NOW(a_rep_string,
        m_tvalid && (result_out.grp == xpp_pkg::GRP_REPNZ || result_out.grp == xpp_pkg::GRP_REPZ),
        !result_out.escape && xpp_pkg::is_string_opcode(result_out.ending_byte),
        "rep prefix kept without string opcode")
    // No fs or gs override is reported for a pre-386 target.
    `XPP_ASSERT_NOW(a_seg_pre386, m_tvalid && !cpu_386_reg,
        result_out.seg != xpp_pkg::SEG_FS && result_out.seg != xpp_pkg::SEG_GS,
        "fs or gs reported on pre-386 target")

endmodule

// ===== verif/x86_prefix_parser_unit_checker.sv =====
// Checker for the x86 prefix parser: watches the configuration, byte and result channels,
// tracks the prefix run on its own and compares every result with the decode it predicts.
// Depends on xpp_pkg for the result layout, the enums and the prefix encodings.
module x86_prefix_parser_unit_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic        cfg_data,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,
    input  logic        m_tuser,
    output int unsigned mismatch_count,
    output int unsigned results_pending
);

    // Shadow of the mode bit and of the prefixes gathered so far.
    logic                fsgs_enabled;
    xpp_pkg::run_state_t collected;
    xpp_pkg::result_t    expected_decodes[$];
    int unsigned         fail_total;

    // Compares one field of a result and records a mismatch.
    task automatic check_field(input string field, input logic [7:0] want,
                               input logic [7:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected %0h, actual %0h", field, want, got);
            fail_total = fail_total + 1;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        xpp_pkg::result_t oldest;
        xpp_pkg::result_t decoded;
        xpp_pkg::seg_t    seg_of_byte;
        xpp_pkg::grp_t    grp_of_byte;
        logic [7:0]       b;

        if (!rst_n)
        begin
            fsgs_enabled = 1'b1;
            collected = xpp_pkg::RUN_CLEAR;
            expected_decodes.delete();
            fail_total = 0;
            mismatch_count <= 0;
            results_pending <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                fsgs_enabled = cfg_data;

            // A result leaving the block is matched against the oldest open decode.
            if (m_tvalid && m_tready)
            begin
                if (expected_decodes.size() == 0)
                begin
                    $error("result with no decode pending: tdata %h, tuser %b",
                           m_tdata, m_tuser);
                    fail_total = fail_total + 1;
                end
                else
                begin
                    oldest = expected_decodes.pop_front();
                    check_field("segment_override", 8'(oldest.seg), 8'(m_tdata[2:0]));
                    check_field("operand_size_override", 8'(oldest.opsize), 8'(m_tdata[3]));
                    check_field("address_size_override", 8'(oldest.addrsize),
                                8'(m_tdata[4]));
                    check_field("lock_rep_wait", 8'(oldest.grp), 8'(m_tdata[7:5]));
                    check_field("ending_byte", oldest.ending_byte, m_tdata[15:8]);
                    check_field("prefix_count", 8'(oldest.count), 8'(m_tdata[19:16]));
                    check_field("tdata padding", 8'd0, 8'(m_tdata[23:20]));
                    check_field("two_byte_escape", 8'(oldest.escape), 8'(m_tuser));
                end
            end

            // An accepted byte either extends the prefix run or closes it.
            if (s_tvalid && s_tready)
            begin
                b = s_tdata;
                case (b)
                    xpp_pkg::BYTE_ES: seg_of_byte = xpp_pkg::SEG_ES;
                    xpp_pkg::BYTE_CS: seg_of_byte = xpp_pkg::SEG_CS;
                    xpp_pkg::BYTE_SS: seg_of_byte = xpp_pkg::SEG_SS;
                    xpp_pkg::BYTE_DS: seg_of_byte = xpp_pkg::SEG_DS;
                    xpp_pkg::BYTE_FS: seg_of_byte = xpp_pkg::SEG_FS;
                    xpp_pkg::BYTE_GS: seg_of_byte = xpp_pkg::SEG_GS;
                    default:          seg_of_byte = xpp_pkg::SEG_NONE;
                endcase
                case (b)
                    xpp_pkg::BYTE_WAIT:  grp_of_byte = xpp_pkg::GRP_WAIT;
                    xpp_pkg::BYTE_LOCK:  grp_of_byte = xpp_pkg::GRP_LOCK;
                    xpp_pkg::BYTE_REPNZ: grp_of_byte = xpp_pkg::GRP_REPNZ;
                    xpp_pkg::BYTE_REPZ:  grp_of_byte = xpp_pkg::GRP_REPZ;
                    default:             grp_of_byte = xpp_pkg::GRP_NONE;
                endcase

                if (seg_of_byte != xpp_pkg::SEG_NONE || grp_of_byte != xpp_pkg::GRP_NONE ||
                    b == xpp_pkg::BYTE_OPSIZE || b == xpp_pkg::BYTE_ADDRSIZE)
                begin
                    // Only the first prefix of each group sticks.
                    if (seg_of_byte != xpp_pkg::SEG_NONE && collected.seg == xpp_pkg::SEG_NONE)
                        collected.seg = seg_of_byte;
                    if (grp_of_byte != xpp_pkg::GRP_NONE && collected.grp == xpp_pkg::GRP_NONE)
                        collected.grp = grp_of_byte;
                    if (b == xpp_pkg::BYTE_OPSIZE)
                        collected.opsize = 1'b1;
                    if (b == xpp_pkg::BYTE_ADDRSIZE)
                        collected.addrsize = 1'b1;
                    if (collected.count != xpp_pkg::COUNT_MAX)
                        collected.count = collected.count + 4'd1;
                end
                else
                begin
                    decoded.seg = collected.seg;
                    decoded.opsize = collected.opsize;
                    decoded.addrsize = collected.addrsize;
                    decoded.grp = collected.grp;
                    decoded.escape = (b == xpp_pkg::BYTE_ESCAPE);
                    decoded.ending_byte = b;
                    decoded.count = collected.count;

                    // Rep survives only in front of a one-byte string opcode.
                    if ((decoded.grp == xpp_pkg::GRP_REPNZ ||
                         decoded.grp == xpp_pkg::GRP_REPZ) &&
                        !(b inside {[8'h6C:8'h6F], [8'hA4:8'hA7], [8'hAA:8'hAF]}))
                        decoded.grp = xpp_pkg::GRP_NONE;
                    if (decoded.grp == xpp_pkg::GRP_LOCK && !s_tuser)
                        decoded.grp = xpp_pkg::GRP_NONE;
                    // Older processors have no fs or gs.
                    if (!fsgs_enabled &&
                        (decoded.seg == xpp_pkg::SEG_FS || decoded.seg == xpp_pkg::SEG_GS))
                        decoded.seg = xpp_pkg::SEG_NONE;

                    expected_decodes.push_back(decoded);
                    collected = xpp_pkg::RUN_CLEAR;
                end
            end

            mismatch_count <= fail_total;
            results_pending <= expected_decodes.size();
        end
    end

endmodule

// ===== verif/x86_prefix_parser_unit_tb.sv =====
// Testbench top for the x86 prefix parser: clock, reset, byte stream, result back-pressure
// and mode writes. Depends on xpp_pkg, x86_prefix_parser_unit and its checker module.
module x86_prefix_parser_unit_tb;

    localparam int unsigned WATCHDOG_LIMIT = 1000;
    localparam int unsigned SETTLE_CYCLES = 6;

    // Every prefix byte, used to build runs.
    localparam logic [7:0] PREFIXES [12] = '{
        xpp_pkg::BYTE_ES, xpp_pkg::BYTE_CS, xpp_pkg::BYTE_SS, xpp_pkg::BYTE_DS,
        xpp_pkg::BYTE_FS, xpp_pkg::BYTE_GS, xpp_pkg::BYTE_OPSIZE, xpp_pkg::BYTE_ADDRSIZE,
        xpp_pkg::BYTE_WAIT, xpp_pkg::BYTE_LOCK, xpp_pkg::BYTE_REPNZ, xpp_pkg::BYTE_REPZ
    };

    // Directed stream, {lock_allowed, code_byte}; every run ends with a non-prefix byte.
    localparam logic [8:0] DIRECTED [24] = '{
        {1'b0, 8'h00},
        {1'b1, 8'hFF},
        {1'b1, xpp_pkg::BYTE_REPZ}, {1'b1, xpp_pkg::BYTE_ESCAPE},
        {1'b0, xpp_pkg::BYTE_REPZ}, {1'b0, 8'hA4},
        {1'b0, xpp_pkg::BYTE_REPNZ}, {1'b1, 8'hAF},
        {1'b1, xpp_pkg::BYTE_REPNZ}, {1'b0, 8'h90},
        {1'b0, xpp_pkg::BYTE_LOCK}, {1'b1, 8'h87},
        {1'b1, xpp_pkg::BYTE_LOCK}, {1'b0, 8'h87},
        {1'b0, xpp_pkg::BYTE_WAIT}, {1'b1, xpp_pkg::BYTE_REPZ}, {1'b0, 8'hD9},
        {1'b0, xpp_pkg::BYTE_CS}, {1'b1, xpp_pkg::BYTE_DS}, {1'b0, xpp_pkg::BYTE_OPSIZE},
        {1'b1, xpp_pkg::BYTE_ADDRSIZE},
        {1'b0, 8'h8B},
        {1'b1, xpp_pkg::BYTE_GS}, {1'b0, 8'h8B}
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_data = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        m_tuser;

    int unsigned mismatch_count;
    int unsigned results_pending;
    int unsigned bytes_sent = 0;
    int unsigned stall_left = 0;
    int unsigned quiet_cycles = 0;
    logic        idling_on = 1'b1;

    always #10 clk = ~clk;

    x86_prefix_parser_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    x86_prefix_parser_unit_checker i_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .mismatch_count  (mismatch_count),
        .results_pending (results_pending)
    );

    // Result side: ready drops in random bursts while idling is on.
    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            m_tready <= 1'b0;
        end
        else if (idling_on && $urandom_range(0, 4) == 0)
        begin
            stall_left <= $urandom_range(0, 6);
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    // Watchdog on cycles in which no request of any channel completes.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles == WATCHDOG_LIMIT)
        begin
            $display("x86_prefix_parser_unit test failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Offers one byte, possibly after a gap, and returns at the edge that takes it.
    task automatic send_byte(input logic [7:0] code, input logic lock_ok);
        if (idling_on && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= code;
        s_tuser <= lock_ok;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        bytes_sent = bytes_sent + 1;
    endtask

    // One instruction head: a prefix run of random length, sometimes noise, then an opcode.
    task automatic send_instruction();
        int unsigned pick;
        int unsigned run_length;
        logic [7:0]  opcode;

        pick = $urandom_range(0, 15);
        if (pick < 6)
            run_length = 0;
        else if (pick < 12)
            run_length = $urandom_range(1, 3);
        else if (pick < 15)
            run_length = $urandom_range(4, 8);
        else
            run_length = $urandom_range(12, 20);
        repeat (run_length)
            send_byte(PREFIXES[$urandom_range(0, 11)], 1'($urandom_range(0, 1)));

        // Unfiltered bytes now and then, which may close the run early.
        if ($urandom_range(0, 9) == 0)
            repeat ($urandom_range(1, 4))
                send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));

        // String opcodes and their neighbors, the escape, or any other non-prefix byte.
        pick = $urandom_range(0, 9);
        if (pick < 3)
            opcode = ($urandom_range(0, 1) != 0) ? 8'($urandom_range(8'h6B, 8'h70))
                                                 : 8'($urandom_range(8'hA3, 8'hB0));
        else if (pick == 3)
            opcode = xpp_pkg::BYTE_ESCAPE;
        else
            do
                opcode = 8'($urandom_range(0, 255));
            while (opcode inside {xpp_pkg::BYTE_ES, xpp_pkg::BYTE_CS, xpp_pkg::BYTE_SS,
                                  xpp_pkg::BYTE_DS, xpp_pkg::BYTE_FS, xpp_pkg::BYTE_GS,
                                  xpp_pkg::BYTE_OPSIZE, xpp_pkg::BYTE_ADDRSIZE,
                                  xpp_pkg::BYTE_WAIT, xpp_pkg::BYTE_LOCK,
                                  xpp_pkg::BYTE_REPNZ, xpp_pkg::BYTE_REPZ});
        send_byte(opcode, 1'($urandom_range(0, 1)));
    endtask

    // Holds the byte stream until every decode is out and the pipeline has settled.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (results_pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes the processor mode bit with the block idle.
    task automatic write_cpu_mode(input logic is_386);
        drain();
        cfg_valid <= 1'b1;
        cfg_data <= is_386;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed checks with the reset mode, fs and gs allowed.
        foreach (DIRECTED[i])
            send_byte(DIRECTED[i][7:0], DIRECTED[i][8]);

        // Random runs across mode changes, with one full pause by the sender.
        write_cpu_mode(1'b0);
        while (bytes_sent < 350)
            send_instruction();
        drain();
        while (bytes_sent < 550)
            send_instruction();
        write_cpu_mode(1'b1);
        while (bytes_sent < 800)
            send_instruction();
        write_cpu_mode(1'b0);
        while (bytes_sent < 950)
            send_instruction();
        write_cpu_mode(1'b1);

        // Final stretch at full rate on both sides.
        idling_on = 1'b0;
        while (bytes_sent < 1150)
            send_instruction();
        drain();

        if (results_pending != 0)
            $error("%0d predicted results never arrived", results_pending);
        if (mismatch_count == 0 && results_pending == 0)
            $display("x86_prefix_parser_unit test passed");
        else
            $display("x86_prefix_parser_unit test failed");
        $finish;
    end

endmodule
